// ----- design/ascii_distance_line_parser_core_assert.svh -----
// Assertion macros shared by the checker of the distance line parser.
// Needs nothing beyond the language itself; each macro makes one labeled assertion.
`ifndef ASCII_DISTANCE_LINE_PARSER_CORE_ASSERT_SVH
`define ASCII_DISTANCE_LINE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define ADLP_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("adlp assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ADLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("adlp assertion failed");

`endif

// ----- design/adlp_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants for the ASCII distance line parser.
// Used by every module of the block; depends on nothing.
package adlp_pkg;

    typedef enum logic [2:0] {
        ST_WAIT   = 3'd0,
        ST_OK     = 3'd1,
        ST_ZERO   = 3'd2,
        ST_FORMAT = 3'd3,
        ST_UART   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        KIND_NORX   = 3'd0,
        KIND_STALE  = 3'd1,
        KIND_ZERO   = 3'd2,
        KIND_FORMAT = 3'd3,
        KIND_RXERR  = 3'd4,
        KIND_WAIT   = 3'd5,
        KIND_VALUE  = 3'd6
    } kind_t;

    typedef enum logic {
        CMD_RX    = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    localparam logic [7:0]  BYTE_RX_ERR   = 8'hFF;
    localparam logic [7:0]  BYTE_CR       = 8'h0D;
    localparam logic [7:0]  BYTE_LF       = 8'h0A;
    localparam logic [7:0]  BYTE_ZERO     = 8'h30;
    localparam logic [7:0]  BYTE_NINE     = 8'h39;
    localparam logic [2:0]  MAX_DIGITS    = 3'd5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [5:0]  CHAR_ZERO     = 6'd48;
    localparam logic [5:0]  CHAR_SPACE    = 6'd32;

    localparam int DATA_IN_W  = 40;
    localparam int USER_IN_W  = 1;
    localparam int DATA_OUT_W = 56;
    localparam int USER_OUT_W = 3;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  rx_byte;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        valid;
        logic [15:0] distance;
        kind_t       kind;
    } parse_result_t;

    typedef logic [4:0][5:0] digit_chars_t;

endpackage

// ----- design/adlp_parse.sv -----
`timescale 1ns / 1ps
// Line parser state, byte handling and display classification for one word.
// Depends on adlp_pkg.
module adlp_parse
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    input  logic                   load,
    input  adlp_pkg::item_t        item,
    output adlp_pkg::parse_result_t result
);

    logic [15:0]       timeout_reg;
    logic [16:0]       pv_reg, pv_next;
    logic [2:0]        dc_reg, dc_next;
    logic              inv_reg, inv_next;
    adlp_pkg::status_t st_reg, st_next;
    logic              vf_reg, vf_next;
    logic              seen_reg, seen_next;
    logic [31:0]       byte_time_reg, byte_time_next;
    logic [31:0]       sample_time_reg, sample_time_next;
    logic [15:0]       held_reg, held_next;

    logic              is_digit;
    logic              aged_gap;
    logic [31:0]       gap_age;
    logic [31:0]       byte_age;
    logic [31:0]       sample_age;
    logic              byte_old;
    logic              sample_old;
    logic [19:0]       pv_times10;
    adlp_pkg::kind_t   kind;

    assign is_digit = (item.rx_byte >= adlp_pkg::BYTE_ZERO) &&
                      (item.rx_byte <= adlp_pkg::BYTE_NINE);
    assign gap_age  = item.time_ms - byte_time_reg;
    assign aged_gap = gap_age >= {16'd0, timeout_reg};

    always_comb
    begin
        pv_next          = pv_reg;
        dc_next          = dc_reg;
        inv_next         = inv_reg;
        st_next          = st_reg;
        vf_next          = vf_reg;
        seen_next        = seen_reg;
        byte_time_next   = byte_time_reg;
        sample_time_next = sample_time_reg;
        held_next        = held_reg;
        pv_times10       = {pv_reg, 3'b000} + {2'b00, pv_reg, 1'b0} +
                           {12'd0, 8'(item.rx_byte - adlp_pkg::BYTE_ZERO)};
        if (item.command == adlp_pkg::CMD_RX)
        begin
            // A partial line broken by a long gap is dropped as a format error, unless a receive error is shown.
            if (seen_reg && (dc_reg != 3'd0 || inv_reg) && aged_gap)
            begin
                pv_next  = 17'd0;
                dc_next  = 3'd0;
                inv_next = 1'b1;
                if (st_reg != adlp_pkg::ST_UART)
                begin
                    st_next = adlp_pkg::ST_FORMAT;
                end
            end
            pv_times10     = {pv_next, 3'b000} + {2'b00, pv_next, 1'b0} +
                             {12'd0, 8'(item.rx_byte - adlp_pkg::BYTE_ZERO)};
            byte_time_next = item.time_ms;
            seen_next      = 1'b1;
            priority if (item.rx_byte == adlp_pkg::BYTE_RX_ERR)
            begin
                st_next  = adlp_pkg::ST_UART;
                vf_next  = 1'b0;
                pv_next  = 17'd0;
                dc_next  = 3'd0;
                inv_next = 1'b1;
            end
            else if (item.rx_byte == adlp_pkg::BYTE_CR || item.rx_byte == adlp_pkg::BYTE_LF)
            begin
                if (dc_next != 3'd0 && !inv_next && !pv_next[16])
                begin
                    held_next        = pv_next[15:0];
                    sample_time_next = item.time_ms;
                    vf_next          = (pv_next[15:0] != 16'd0);
                    st_next          = (pv_next[15:0] != 16'd0) ? adlp_pkg::ST_OK
                                                                : adlp_pkg::ST_ZERO;
                end
                else if (dc_next != 3'd0 && pv_next[16])
                begin
                    st_next = adlp_pkg::ST_FORMAT;
                end
                pv_next  = 17'd0;
                dc_next  = 3'd0;
                inv_next = 1'b0;
            end
            else if (is_digit && !inv_next && dc_next < adlp_pkg::MAX_DIGITS)
            begin
                if (dc_next == 3'd0)
                begin
                    st_next = adlp_pkg::ST_WAIT;
                end
                pv_next = pv_times10[16:0];
                dc_next = 3'(dc_next + 3'd1);
            end
            else
            begin
                if (st_next != adlp_pkg::ST_UART &&
                    (!is_digit || dc_next >= adlp_pkg::MAX_DIGITS))
                begin
                    st_next = adlp_pkg::ST_FORMAT;
                end
                inv_next = 1'b1;
            end
        end
    end

    assign byte_age   = item.time_ms - byte_time_next;
    assign sample_age = item.time_ms - sample_time_next;
    assign byte_old   = byte_age >= {16'd0, timeout_reg};
    assign sample_old = sample_age >= {16'd0, timeout_reg};

    always_comb
    begin
        kind = adlp_pkg::KIND_VALUE;
        if (!seen_next)
        begin
            kind = adlp_pkg::KIND_NORX;
        end
        else if (byte_old)
        begin
            kind = adlp_pkg::KIND_STALE;
        end
        else if (!vf_next || sample_old)
        begin
            unique case (st_next)
                adlp_pkg::ST_OK:     kind = adlp_pkg::KIND_STALE;
                adlp_pkg::ST_ZERO:   kind = sample_old ? adlp_pkg::KIND_STALE
                                                       : adlp_pkg::KIND_ZERO;
                adlp_pkg::ST_FORMAT: kind = adlp_pkg::KIND_FORMAT;
                adlp_pkg::ST_UART:   kind = adlp_pkg::KIND_RXERR;
                default:             kind = adlp_pkg::KIND_WAIT;
            endcase
        end
    end

    assign result.status   = st_next;
    assign result.valid    = vf_next;
    assign result.distance = held_next;
    assign result.kind     = kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= adlp_pkg::TIMEOUT_RESET;
            pv_reg          <= 17'd0;
            dc_reg          <= 3'd0;
            inv_reg         <= 1'b1;
            st_reg          <= adlp_pkg::ST_WAIT;
            vf_reg          <= 1'b0;
            seen_reg        <= 1'b0;
            byte_time_reg   <= 32'd0;
            sample_time_reg <= 32'd0;
            held_reg        <= 16'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (load)
            begin
                pv_reg          <= pv_next;
                dc_reg          <= dc_next;
                inv_reg         <= inv_next;
                st_reg          <= st_next;
                vf_reg          <= vf_next;
                seen_reg        <= seen_next;
                byte_time_reg   <= byte_time_next;
                sample_time_reg <= sample_time_next;
                held_reg        <= held_next;
            end
        end
    end

endmodule

// ----- design/adlp_digits.sv -----
`timescale 1ns / 1ps
// Splits a 16-bit distance into five right-aligned ASCII digit characters.
// Depends on adlp_pkg.
module adlp_digits
(
    input  logic [15:0]            distance,
    input  adlp_pkg::kind_t        kind,
    output adlp_pkg::digit_chars_t chars
);

    localparam int unsigned DEC_POW [5] = '{1, 10, 100, 1000, 10000};

    logic [4:0][3:0] digits;
    logic [15:0]     rem;
    logic [3:0]      d;

    // Four compare-and-subtract steps, highest decade first.
    always_comb
    begin
        rem = distance;
        digits = '0;
        for (int pos = 4; pos >= 1; pos--)
        begin
            d = 4'd0;
            for (int k = 1; k <= 9; k++)
            begin
                if ({1'b0, rem} >= 17'(k * DEC_POW[pos]))
                begin
                    d = 4'(k);
                end
            end
            rem = 16'(int'(rem) - int'(d) * DEC_POW[pos]);
            digits[pos] = d;
        end
        digits[0] = rem[3:0];
    end

    always_comb
    begin
        chars = '0;
        if (kind == adlp_pkg::KIND_VALUE)
        begin
            chars[0] = 6'(adlp_pkg::CHAR_ZERO + {2'b00, digits[0]});
            for (int pos = 1; pos <= 4; pos++)
            begin
                chars[pos] = (distance >= 16'(DEC_POW[pos]))
                           ? 6'(adlp_pkg::CHAR_ZERO + {2'b00, digits[pos]})
                           : adlp_pkg::CHAR_SPACE;
            end
        end
    end

endmodule

// ----- design/ascii_distance_line_parser_core.sv -----
`timescale 1ns / 1ps
// ASCII distance line parser, top level: input register, parse stage, digit stage.
// Each word passes through these stages in turn; its result word is driven from the digit stage register.
// Throughput is one word per cycle; a stage holds only while the stage after it is full
// and cannot move on. Reset clears the pipeline and the parser state; the timeout
// register resets to 500 ms. Depends on adlp_pkg, adlp_parse and adlp_digits.
module ascii_distance_line_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] rx_byte, [39:8] time_ms
    input  logic [adlp_pkg::DATA_IN_W-1:0]  s_tdata,
    // [0] command
    input  logic [adlp_pkg::USER_IN_W-1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] line_status, [3] reading_valid, [19:4] distance, [25:20] digit_char_4,
    // [31:26] digit_char_3, [37:32] digit_char_2, [43:38] digit_char_1,
    // [49:44] digit_char_0, [55:50] zero
    output logic [adlp_pkg::DATA_OUT_W-1:0] m_tdata,
    // [2:0] display_kind
    output logic [adlp_pkg::USER_OUT_W-1:0] m_tuser
);

    logic                    a_valid_reg, a_valid_next;
    logic                    b_valid_reg, b_valid_next;
    logic                    c_valid_reg, c_valid_next;
    adlp_pkg::item_t         a_item_reg;
    adlp_pkg::parse_result_t b_res_reg;
    adlp_pkg::parse_result_t c_res_reg;
    adlp_pkg::digit_chars_t  c_chars_reg;

    logic                    a_ready, b_ready, c_ready;
    adlp_pkg::parse_result_t parse_res;
    adlp_pkg::digit_chars_t  chars;

    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    assign a_valid_next = a_ready ? s_tvalid    : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    adlp_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .load        (a_valid_reg && b_ready),
        .item        (a_item_reg),
        .result      (parse_res)
    );

    adlp_digits u_digits
    (
        .distance (b_res_reg.distance),
        .kind     (b_res_reg.kind),
        .chars    (chars)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && a_ready)
        begin
            a_item_reg.command <= adlp_pkg::cmd_t'(s_tuser[0]);
            a_item_reg.rx_byte <= s_tdata[7:0];
            a_item_reg.time_ms <= s_tdata[39:8];
        end
        if (a_valid_reg && b_ready)
        begin
            b_res_reg <= parse_res;
        end
        if (b_valid_reg && c_ready)
        begin
            c_res_reg   <= b_res_reg;
            c_chars_reg <= chars;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {6'd0, c_chars_reg[0], c_chars_reg[1], c_chars_reg[2],
                       c_chars_reg[3], c_chars_reg[4], c_res_reg.distance,
                       c_res_reg.valid, c_res_reg.status};
    assign m_tuser  = c_res_reg.kind;

endmodule

// ----- design/adlp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the result stream of the distance line parser, bound to the top.
// Depends on adlp_pkg and ascii_distance_line_parser_core_assert.svh.
`include "ascii_distance_line_parser_core_assert.svh"

module adlp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [adlp_pkg::DATA_OUT_W-1:0]   m_tdata,
    input logic [adlp_pkg::USER_OUT_W-1:0]   m_tuser
);

    logic                                                   out_stalled;
    logic                                                   out_value;
    logic                                                   units_is_digit;
    logic [15:0]                                            out_distance;
    logic [adlp_pkg::DATA_OUT_W+adlp_pkg::USER_OUT_W-1:0]   out_word;

    assign out_stalled    = m_tvalid && !m_tready;
    assign out_value      = m_tvalid && (m_tuser == adlp_pkg::KIND_VALUE);
    assign out_distance   = m_tdata[19:4];
    assign out_word       = {m_tuser, m_tdata};
    assign units_is_digit = (m_tdata[49:44] >= adlp_pkg::CHAR_ZERO) &&
                            (m_tdata[49:44] <= 6'(adlp_pkg::BYTE_NINE));

    `ADLP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, m_tvalid && $stable(out_word))

    `ADLP_ASSERT_NOW(a_blank_digits, clk, rst_n, m_tvalid && !out_value, m_tdata[49:20] == 30'd0)

    `ADLP_ASSERT_NOW(a_value_needs_reading, clk, rst_n, out_value, m_tdata[3] && out_distance != '0)

    `ADLP_ASSERT_NOW(a_valid_nonzero, clk, rst_n, m_tvalid && m_tdata[3], out_distance != 16'd0)

    `ADLP_ASSERT_NOW(a_units_digit, clk, rst_n, out_value, units_is_digit)

endmodule

bind ascii_distance_line_parser_core adlp_checker u_adlp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/tb_ascii_distance_line_parser_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII distance line parser core: byte and query words
// are streamed in with random gaps and stalls, and each result word is checked against a
// cycle-free model of the parser and its display. Depends on adlp_pkg and the core.
module tb_ascii_distance_line_parser_core;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 8;
    localparam int LATENCY = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 63;
    localparam int NUM_PHASES = 6;
    localparam int IDLE_PERCENT = 13;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        adlp_pkg::parse_result_t res;
        adlp_pkg::digit_chars_t  chars;
    } reading_t;

    class distance_display_tracker;
        reading_t          due_readings[$];
        int                errors;
        logic [15:0]       timeout;
        logic [16:0]       partial;
        logic [2:0]        digit_count;
        logic              line_invalid;
        adlp_pkg::status_t status;
        logic              valid;
        logic              seen;
        logic [31:0]       byte_stamp;
        logic [31:0]       sample_stamp;
        logic [15:0]       held;

        function new();
            errors = 0;
            timeout = adlp_pkg::TIMEOUT_RESET;
            partial = '0;
            digit_count = '0;
            line_invalid = 1'b1;
            status = adlp_pkg::ST_WAIT;
            valid = 1'b0;
            seen = 1'b0;
            byte_stamp = '0;
            sample_stamp = '0;
            held = '0;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout = value;
        endfunction

        function int pending();
            return due_readings.size();
        endfunction

        function bit aged(logic [31:0] now_t, logic [31:0] then_t);
            logic [31:0] age;
            age = now_t - then_t;
            return age >= {16'd0, timeout};
        endfunction

        function void note_word(adlp_pkg::cmd_t cmd, logic [7:0] b, logic [31:0] t);
            reading_t        exp_r;
            adlp_pkg::kind_t kind;
            logic            is_digit;
            logic            sample_old;
            logic [15:0]     v;
            int              k;
            is_digit = (b >= adlp_pkg::BYTE_ZERO) && (b <= adlp_pkg::BYTE_NINE);
            if (cmd == adlp_pkg::CMD_RX)
            begin
                // A partial line interrupted by a long gap is thrown away.
                if (seen && (digit_count != 0 || line_invalid) && aged(t, byte_stamp))
                begin
                    partial = '0;
                    digit_count = '0;
                    line_invalid = 1'b1;
                    if (status != adlp_pkg::ST_UART)
                        status = adlp_pkg::ST_FORMAT;
                end
                byte_stamp = t;
                seen = 1'b1;
                if (b == adlp_pkg::BYTE_RX_ERR)
                begin
                    status = adlp_pkg::ST_UART;
                    valid = 1'b0;
                    partial = '0;
                    digit_count = '0;
                    line_invalid = 1'b1;
                end
                else if (b == adlp_pkg::BYTE_CR || b == adlp_pkg::BYTE_LF)
                begin
                    if (digit_count != 0 && !line_invalid && partial <= 17'd65535)
                    begin
                        held = partial[15:0];
                        sample_stamp = t;
                        valid = (held != 0);
                        status = valid ? adlp_pkg::ST_OK : adlp_pkg::ST_ZERO;
                    end
                    else if (digit_count != 0 && partial > 17'd65535)
                        status = adlp_pkg::ST_FORMAT;
                    partial = '0;
                    digit_count = '0;
                    line_invalid = 1'b0;
                end
                else if (is_digit && !line_invalid && digit_count < adlp_pkg::MAX_DIGITS)
                begin
                    if (digit_count == 0)
                        status = adlp_pkg::ST_WAIT;
                    partial = partial * 17'd10 + 17'(b - adlp_pkg::BYTE_ZERO);
                    digit_count++;
                end
                else
                begin
                    line_invalid = 1'b1;
                    if (status != adlp_pkg::ST_UART &&
                        (!is_digit || digit_count >= adlp_pkg::MAX_DIGITS))
                        status = adlp_pkg::ST_FORMAT;
                end
            end

            if (!seen)
                kind = adlp_pkg::KIND_NORX;
            else if (aged(t, byte_stamp))
                kind = adlp_pkg::KIND_STALE;
            else
            begin
                sample_old = aged(t, sample_stamp);
                if (!valid || sample_old)
                begin
                    case (status)
                        adlp_pkg::ST_OK:     kind = adlp_pkg::KIND_STALE;
                        adlp_pkg::ST_ZERO:   kind = sample_old ? adlp_pkg::KIND_STALE
                                                               : adlp_pkg::KIND_ZERO;
                        adlp_pkg::ST_FORMAT: kind = adlp_pkg::KIND_FORMAT;
                        adlp_pkg::ST_UART:   kind = adlp_pkg::KIND_RXERR;
                        default:             kind = adlp_pkg::KIND_WAIT;
                    endcase
                end
                else
                    kind = adlp_pkg::KIND_VALUE;
            end

            exp_r.res.status = status;
            exp_r.res.valid = valid;
            exp_r.res.distance = held;
            exp_r.res.kind = kind;
            exp_r.chars = '0;
            if (kind == adlp_pkg::KIND_VALUE)
            begin
                for (k = 1; k < 5; k++)
                    exp_r.chars[k] = adlp_pkg::CHAR_SPACE;
                v = held;
                k = 0;
                do
                begin
                    exp_r.chars[k] = adlp_pkg::CHAR_ZERO + 6'(v % 16'd10);
                    v = v / 16'd10;
                    k++;
                end
                while (v != 0 && k < 5);
            end
            due_readings.push_back(exp_r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_word(logic [adlp_pkg::DATA_OUT_W-1:0] data,
                                 logic [adlp_pkg::USER_OUT_W-1:0] user);
            reading_t exp_r;
            int       k;
            if (due_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result word %h/%h arrived with nothing outstanding", data, user);
                return;
            end
            exp_r = due_readings.pop_front();
            check_field("line_status", 32'(exp_r.res.status), 32'(data[2:0]));
            check_field("reading_valid", 32'(exp_r.res.valid), 32'(data[3]));
            check_field("distance", 32'(exp_r.res.distance), 32'(data[19:4]));
            check_field("display_kind", 32'(exp_r.res.kind), 32'(user[2:0]));
            for (k = 0; k < 5; k++)
                check_field($sformatf("digit_char_%0d", k), 32'(exp_r.chars[k]),
                            32'(data[20 + 6 * (4 - k) +: 6]));
            check_field("pad bits", 32'd0, 32'(data[55:50]));
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [15:0]                     cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [adlp_pkg::DATA_IN_W-1:0]  s_tdata = '0;
    logic [adlp_pkg::USER_IN_W-1:0]  s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [adlp_pkg::DATA_OUT_W-1:0] m_tdata;
    logic [adlp_pkg::USER_OUT_W-1:0] m_tuser;

    distance_display_tracker tracker = new();
    logic [31:0] now_ms = '0;
    int unsigned cur_timeout = 32'(adlp_pkg::TIMEOUT_RESET);
    bit          steady = 1'b0;
    int          stall_cycles = 0;

    ascii_distance_line_parser_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_word(m_tdata, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_ascii_distance_line_parser_core: errors");
                $finish;
            end
        end
    end

    function automatic logic [31:0] next_gap();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return cur_timeout + $urandom_range(0, 2);
        if (pick == 1)
            return (cur_timeout == 0) ? 0 : cur_timeout - 1;
        return $urandom_range(0, cur_timeout / 3 + 1);
    endfunction

    task automatic send_word(adlp_pkg::cmd_t cmd, logic [7:0] b, logic [31:0] gap);
        now_ms = now_ms + gap;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {now_ms, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_word(cmd, b, now_ms);
    endtask

    task automatic send_text(string txt, logic [31:0] gap);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_word(adlp_pkg::CMD_RX, txt[i], gap);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] phase_timeout [NUM_PHASES];
        int          p;
        int          sent;
        int          n;
        int          i;
        int unsigned r;
        bit          paused;

        phase_timeout = '{16'hFFFF, 16'd1, 16'd0, adlp_pkg::TIMEOUT_RESET,
                          16'($urandom_range(2, 5000)), 16'($urandom_range(1, 65535))};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(adlp_pkg::CMD_QUERY, 8'h5A, 32'd0);
        // An empty line clears the invalid line left over from reset.
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_LF, 32'd10);
        send_text("65535", 32'd7);
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_CR, 32'd7);
        send_word(adlp_pkg::CMD_QUERY, 8'hFF, 32'd100);
        send_text("0", 32'd7);
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_LF, 32'd7);
        send_text("A", 32'd7);
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_LF, 32'd7);
        send_text("65536", 32'd7);
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_LF, 32'd7);
        send_text("7", 32'd7);
        // A gap of exactly the timeout throws the partial line away.
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_LF, 32'(adlp_pkg::TIMEOUT_RESET));
        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_RX_ERR, 32'd3);
        send_word(adlp_pkg::CMD_QUERY, 8'h00, 32'd1000);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= phase_timeout[p];
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            tracker.set_timeout(phase_timeout[p]);
            cur_timeout = 32'(phase_timeout[p]);
            steady = (p == 2);
            // The first phase starts just short of the time wrap.
            now_ms = (p == 0) ? 32'hFFFF_8000 : $urandom;
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_WORDS)
            begin
                if (!paused && sent >= PHASE_WORDS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    n = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 5);
                    for (i = 0; i < n; i++)
                        send_word(adlp_pkg::CMD_RX,
                                  adlp_pkg::BYTE_ZERO + 8'($urandom_range(0, 9)),
                                  next_gap());
                    send_word(adlp_pkg::CMD_RX,
                              $urandom_range(0, 1) ? adlp_pkg::BYTE_CR : adlp_pkg::BYTE_LF,
                              next_gap());
                    sent += n + 1;
                end
                else
                begin
                    if (r < 75)
                        send_word(adlp_pkg::CMD_QUERY, 8'($urandom), next_gap());
                    else if (r < 80)
                        send_word(adlp_pkg::CMD_QUERY, 8'($urandom), $urandom);
                    else if (r < 85)
                        send_word(adlp_pkg::CMD_RX, adlp_pkg::BYTE_RX_ERR, next_gap());
                    else if (r < 93)
                        send_word(adlp_pkg::CMD_RX, 8'($urandom_range(0, 255)), next_gap());
                    else
                        send_word(adlp_pkg::CMD_RX,
                                  $urandom_range(0, 1) ? adlp_pkg::BYTE_CR
                                                       : adlp_pkg::BYTE_LF,
                                  next_gap());
                    sent++;
                end
            end
        end

        settle();
        repeat (4 * LATENCY) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_ascii_distance_line_parser_core: clean");
        else
            $display("tb_ascii_distance_line_parser_core: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/adlp_pkg.sv
design/adlp_parse.sv
design/adlp_digits.sv
design/ascii_distance_line_parser_core.sv
design/adlp_checker.sv
test/tb_ascii_distance_line_parser_core.sv
